// File: src/tsvo_pkg.sv
package tsvo_pkg;

    localparam int SIZE_W      = 31;
    localparam int STRIDE_W    = 40;
    localparam int BOUND_W     = 32;
    localparam int OFF_W       = 48;
    localparam int DIMS_W      = 4;
    localparam int CFG_W       = 48;
    localparam int CFG_IDX_W   = 2;
    localparam int SPLIT_W     = 20;
    localparam int PART_W      = SIZE_W + SPLIT_W;
    localparam int PROD_W      = PART_W + SPLIT_W;
    localparam int TOT_SPLIT_W = 24;
    localparam int TOT_PART_W  = TOT_SPLIT_W + SIZE_W;
    localparam int TOT_PROD_W  = OFF_W + SIZE_W;
    localparam int WIDE_W      = BOUND_W + 1;
    localparam int DIM_TOP     = 15;

    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_PTR_W = 3;
    localparam int QUEUE_CNT_W = 4;
    localparam int FILL_W      = QUEUE_CNT_W + 1;
    localparam int BUSY_W      = 3;

    localparam logic [OFF_W-1:0] OFF_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_COUNT  = 2'd2;

    localparam logic RESULT_DIM     = 1'b0;
    localparam logic RESULT_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        KIND_ALL   = 2'd0,
        KIND_INDEX = 2'd1,
        KIND_RANGE = 2'd2,
        KIND_BAD   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_INDEX  = 3'd1,
        ST_RANGE  = 3'd2,
        ST_KIND   = 3'd3,
        ST_OFFSET = 3'd4,
        ST_REGION = 3'd5
    } status_t;

    typedef struct packed {
        logic [SIZE_W-1:0]          dim_size;
        logic [STRIDE_W-1:0]        dim_stride;
        kind_t                      slice_kind;
        logic signed [BOUND_W-1:0]  first_bound;
        logic signed [BOUND_W-1:0]  second_bound;
        logic                       last_dim;
    } item_t;

    typedef struct packed {
        status_t             err;
        logic                keep;
        logic [SIZE_W-1:0]   ksize;
        logic [STRIDE_W-1:0] kstride;
        logic [SIZE_W-1:0]   idx;
        logic [STRIDE_W-1:0] stride;
        logic                last;
    } dec_t;

    typedef struct packed {
        status_t             err;
        logic                keep;
        logic [SIZE_W-1:0]   ksize;
        logic [STRIDE_W-1:0] kstride;
        logic [PART_W-1:0]   p_lo;
        logic [PART_W-1:0]   p_hi;
        logic                last;
    } part_t;

    typedef struct packed {
        status_t             err;
        logic                keep;
        logic [SIZE_W-1:0]   ksize;
        logic [STRIDE_W-1:0] kstride;
        logic [OFF_W-1:0]    inc;
        logic                inc_clip;
        logic                last;
    } step_t;

    typedef struct packed {
        logic                has_dim;
        logic [SIZE_W-1:0]   view_size;
        logic [STRIDE_W-1:0] view_stride;
        logic                last;
        logic [OFF_W-1:0]    offset;
        logic [OFF_W-1:0]    total;
        status_t             err;
        logic [DIMS_W-1:0]   dims;
        logic                clip;
    } raw_t;

    typedef struct packed {
        logic                has_dim;
        logic [SIZE_W-1:0]   view_size;
        logic [STRIDE_W-1:0] view_stride;
        logic                has_sum;
        logic [OFF_W-1:0]    offset;
        logic [OFF_W-1:0]    total;
        logic [DIMS_W-1:0]   dims;
        status_t             status;
    } entry_t;

    typedef struct packed {
        logic                item_kind;
        logic [SIZE_W-1:0]   view_size;
        logic [STRIDE_W-1:0] view_stride;
        logic [OFF_W-1:0]    view_offset;
        logic [OFF_W-1:0]    view_count;
        logic [DIMS_W-1:0]   view_dims;
        status_t             status;
        logic                last_result;
    } result_t;

endpackage

// File: src/tsvo_in_if.sv
interface tsvo_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [tsvo_pkg::SIZE_W-1:0]           dim_size;
    logic [tsvo_pkg::STRIDE_W-1:0]         dim_stride;
    logic [1:0]                            slice_kind;
    logic signed [tsvo_pkg::BOUND_W-1:0]   first_bound;
    logic signed [tsvo_pkg::BOUND_W-1:0]   second_bound;
    logic                                  last_dim;

    modport source
    (
        output valid, dim_size, dim_stride, slice_kind, first_bound, second_bound, last_dim,
        input  ready
    );

    modport sink
    (
        input  valid, dim_size, dim_stride, slice_kind, first_bound, second_bound, last_dim,
        output ready
    );
endinterface

// File: src/tsvo_out_if.sv
interface tsvo_out_if;
    logic                            valid;
    logic                            ready;
    logic                            item_kind;
    logic [tsvo_pkg::SIZE_W-1:0]     view_size;
    logic [tsvo_pkg::STRIDE_W-1:0]   view_stride;
    logic [tsvo_pkg::OFF_W-1:0]      view_offset;
    logic [tsvo_pkg::OFF_W-1:0]      view_count;
    logic [tsvo_pkg::DIMS_W-1:0]     view_dims;
    logic [2:0]                      status;
    logic                            last_result;

    modport source
    (
        output valid, item_kind, view_size, view_stride, view_offset, view_count,
               view_dims, status, last_result,
        input  ready
    );

    modport sink
    (
        input  valid, item_kind, view_size, view_stride, view_offset, view_count,
               view_dims, status, last_result,
        output ready
    );
endinterface

// File: src/tsvo_front.sv
module tsvo_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        take,
    input  tsvo_pkg::item_t             item,
    input  logic                        view_mode,
    output logic                        step_valid,
    output tsvo_pkg::step_t             step,
    output logic [tsvo_pkg::BUSY_W-1:0] busy
);

    logic            s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    tsvo_pkg::item_t s1_reg;
    tsvo_pkg::dec_t  s2_reg, dec_next;
    tsvo_pkg::part_t s3_reg, part_next;
    tsvo_pkg::step_t s4_reg, step_next;

    logic signed [tsvo_pkg::WIDE_W-1:0] size_s, b0_s, b1_s, b0_w, b1_w, span;
    logic                               idx_bad, rng_bad;
    logic [tsvo_pkg::PROD_W-1:0]        prod;

    // bound wrap and checks
    always_comb
    begin
        size_s  = $signed({2'b00, s1_reg.dim_size});
        b0_s    = $signed({s1_reg.first_bound[tsvo_pkg::BOUND_W-1], s1_reg.first_bound});
        b1_s    = $signed({s1_reg.second_bound[tsvo_pkg::BOUND_W-1], s1_reg.second_bound});
        b0_w    = (view_mode && b0_s < 0) ? b0_s + size_s : b0_s;
        b1_w    = (view_mode && b1_s < 0) ? b1_s + size_s : b1_s;
        idx_bad = (b0_w < 0) || (b0_w >= size_s);
        rng_bad = (b0_w < 0) || (b1_w < b0_w) || (b1_w >= size_s);
        span    = b1_w - b0_w + 33'sd1;

        dec_next         = '0;
        dec_next.err     = tsvo_pkg::ST_OK;
        dec_next.stride  = s1_reg.dim_stride;
        dec_next.last    = s1_reg.last_dim;
        unique case (s1_reg.slice_kind)
            tsvo_pkg::KIND_ALL:
            begin
                dec_next.keep    = 1'b1;
                dec_next.ksize   = s1_reg.dim_size;
                dec_next.kstride = s1_reg.dim_stride;
            end
            tsvo_pkg::KIND_INDEX:
            begin
                if (idx_bad)
                begin
                    dec_next.err = tsvo_pkg::ST_INDEX;
                end
                else
                begin
                    dec_next.idx   = b0_w[tsvo_pkg::SIZE_W-1:0];
                    dec_next.keep  = !view_mode;
                    dec_next.ksize = tsvo_pkg::SIZE_W'(1);
                end
            end
            tsvo_pkg::KIND_RANGE:
            begin
                if (rng_bad)
                begin
                    dec_next.err = tsvo_pkg::ST_RANGE;
                end
                else
                begin
                    dec_next.idx     = b0_w[tsvo_pkg::SIZE_W-1:0];
                    dec_next.keep    = 1'b1;
                    dec_next.ksize   = span[tsvo_pkg::SIZE_W-1:0];
                    dec_next.kstride = s1_reg.dim_stride;
                end
            end
            default:
            begin
                dec_next.err = tsvo_pkg::ST_KIND;
            end
        endcase
    end

    // index times stride as two partial products
    always_comb
    begin
        part_next.err     = s2_reg.err;
        part_next.keep    = s2_reg.keep;
        part_next.ksize   = s2_reg.ksize;
        part_next.kstride = s2_reg.kstride;
        part_next.last    = s2_reg.last;
        part_next.p_lo    = tsvo_pkg::PART_W'(s2_reg.idx)
                          * tsvo_pkg::PART_W'(s2_reg.stride[tsvo_pkg::SPLIT_W-1:0]);
        part_next.p_hi    = tsvo_pkg::PART_W'(s2_reg.idx)
                          * tsvo_pkg::PART_W'(s2_reg.stride[tsvo_pkg::STRIDE_W-1:tsvo_pkg::SPLIT_W]);
    end

    always_comb
    begin
        prod = tsvo_pkg::PROD_W'(s3_reg.p_lo)
             + {s3_reg.p_hi, {tsvo_pkg::SPLIT_W{1'b0}}};
        step_next.err      = s3_reg.err;
        step_next.keep     = s3_reg.keep;
        step_next.ksize    = s3_reg.ksize;
        step_next.kstride  = s3_reg.kstride;
        step_next.last     = s3_reg.last;
        step_next.inc_clip = |prod[tsvo_pkg::PROD_W-1:tsvo_pkg::OFF_W];
        step_next.inc      = step_next.inc_clip ? tsvo_pkg::OFF_MAX
                                                : prod[tsvo_pkg::OFF_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_reg <= item;
        end
        s2_reg <= dec_next;
        s3_reg <= part_next;
        s4_reg <= step_next;
    end

    assign step_valid = s4_valid_reg;
    assign step       = s4_reg;
    assign busy       = tsvo_pkg::BUSY_W'(s1_valid_reg) + tsvo_pkg::BUSY_W'(s2_valid_reg)
                      + tsvo_pkg::BUSY_W'(s3_valid_reg) + tsvo_pkg::BUSY_W'(s4_valid_reg);

endmodule

// File: src/tsvo_accum.sv
module tsvo_accum
#(
    parameter int DIM_LIMIT = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step_valid,
    input  tsvo_pkg::step_t            step,
    input  logic [tsvo_pkg::OFF_W-1:0] base_offset,
    output logic                       ent_valid,
    output tsvo_pkg::raw_t             ent
);

    localparam logic [tsvo_pkg::DIMS_W-1:0] DIM_CAP =
        tsvo_pkg::DIMS_W'((DIM_LIMIT > tsvo_pkg::DIM_TOP) ? tsvo_pkg::DIM_TOP : DIM_LIMIT);

    logic [tsvo_pkg::OFF_W-1:0]  offset_reg, total_reg;
    tsvo_pkg::status_t           err_reg;
    logic [tsvo_pkg::DIMS_W-1:0] dims_reg;
    logic                        clip_reg, at_start_reg;
    logic                        ent_valid_reg;
    tsvo_pkg::raw_t              ent_reg;

    logic [tsvo_pkg::OFF_W-1:0]      cur_off, cur_tot, offset_next, total_next;
    tsvo_pkg::status_t               cur_err, err_next;
    logic [tsvo_pkg::DIMS_W-1:0]     cur_dims, dims_next;
    logic                            cur_clip, clip_next, emit;
    logic [tsvo_pkg::OFF_W:0]        off_sum;
    logic [tsvo_pkg::TOT_PART_W-1:0] tot_hi, tot_lo;
    logic [tsvo_pkg::TOT_PROD_W-1:0] tot_prod;
    logic                            tot_sat;

    always_comb
    begin
        cur_off  = at_start_reg ? base_offset : offset_reg;
        cur_tot  = at_start_reg ? tsvo_pkg::OFF_W'(1) : total_reg;
        cur_err  = at_start_reg ? tsvo_pkg::ST_OK : err_reg;
        cur_dims = at_start_reg ? '0 : dims_reg;
        cur_clip = at_start_reg ? 1'b0 : clip_reg;

        off_sum  = {1'b0, cur_off} + {1'b0, step.inc};
        tot_hi   = tsvo_pkg::TOT_PART_W'(cur_tot[tsvo_pkg::OFF_W-1:tsvo_pkg::TOT_SPLIT_W])
                 * tsvo_pkg::TOT_PART_W'(step.ksize);
        tot_lo   = tsvo_pkg::TOT_PART_W'(cur_tot[tsvo_pkg::TOT_SPLIT_W-1:0])
                 * tsvo_pkg::TOT_PART_W'(step.ksize);
        tot_prod = {tot_hi, {tsvo_pkg::TOT_SPLIT_W{1'b0}}} + tsvo_pkg::TOT_PROD_W'(tot_lo);
        tot_sat  = |tot_prod[tsvo_pkg::TOT_PROD_W-1:tsvo_pkg::OFF_W];

        offset_next = cur_off;
        total_next  = cur_tot;
        err_next    = cur_err;
        dims_next   = cur_dims;
        clip_next   = cur_clip;
        emit        = 1'b0;

        // once an error is held the rest of the view is skipped
        if (cur_err == tsvo_pkg::ST_OK)
        begin
            if (step.err != tsvo_pkg::ST_OK)
            begin
                err_next = step.err;
            end
            else
            begin
                offset_next = off_sum[tsvo_pkg::OFF_W] ? tsvo_pkg::OFF_MAX
                                                       : off_sum[tsvo_pkg::OFF_W-1:0];
                clip_next   = cur_clip | step.inc_clip | off_sum[tsvo_pkg::OFF_W];
                if (step.keep)
                begin
                    if (cur_dims >= DIM_CAP)
                    begin
                        err_next = tsvo_pkg::ST_KIND;
                    end
                    else
                    begin
                        total_next = tot_sat ? tsvo_pkg::OFF_MAX
                                             : tot_prod[tsvo_pkg::OFF_W-1:0];
                        clip_next  = clip_next | tot_sat;
                        dims_next  = cur_dims + tsvo_pkg::DIMS_W'(1);
                        emit       = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            total_reg     <= tsvo_pkg::OFF_W'(1);
            err_reg       <= tsvo_pkg::ST_OK;
            dims_reg      <= '0;
            clip_reg      <= 1'b0;
            at_start_reg  <= 1'b1;
            ent_valid_reg <= 1'b0;
        end
        else
        begin
            ent_valid_reg <= step_valid && (emit || step.last);
            if (step_valid)
            begin
                offset_reg   <= offset_next;
                total_reg    <= total_next;
                err_reg      <= err_next;
                dims_reg     <= dims_next;
                clip_reg     <= clip_next;
                at_start_reg <= step.last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg.has_dim     <= emit;
        ent_reg.view_size   <= step.ksize;
        ent_reg.view_stride <= step.kstride;
        ent_reg.last        <= step.last;
        ent_reg.offset      <= offset_next;
        ent_reg.total       <= total_next;
        ent_reg.err         <= err_next;
        ent_reg.dims        <= dims_next;
        ent_reg.clip        <= clip_next;
    end

    assign ent_valid = ent_valid_reg;
    assign ent       = ent_reg;

endmodule

// File: src/tsvo_out_queue.sv
module tsvo_out_queue
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  tsvo_pkg::raw_t                   raw,
    input  logic [tsvo_pkg::OFF_W-1:0]       base_count,
    input  logic                             out_ready,
    output logic                             out_valid,
    output tsvo_pkg::result_t                result,
    output logic [tsvo_pkg::QUEUE_CNT_W-1:0] level
);

    tsvo_pkg::entry_t                 mem [tsvo_pkg::QUEUE_DEPTH];
    logic [tsvo_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [tsvo_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic                             phase_reg;

    tsvo_pkg::entry_t           wr_entry, head;
    tsvo_pkg::status_t          st;
    logic [tsvo_pkg::OFF_W:0]   end_pos;
    logic                       show_dim, advance, pop;

    // summary status at the end of a view
    always_comb
    begin
        end_pos = {1'b0, raw.offset} + {1'b0, raw.total};
        if (raw.err != tsvo_pkg::ST_OK)
        begin
            st = raw.err;
        end
        else if (raw.offset >= base_count)
        begin
            st = tsvo_pkg::ST_OFFSET;
        end
        else if (end_pos > {1'b0, base_count} || raw.clip)
        begin
            st = tsvo_pkg::ST_REGION;
        end
        else
        begin
            st = tsvo_pkg::ST_OK;
        end

        wr_entry.has_dim     = raw.has_dim;
        wr_entry.view_size   = raw.view_size;
        wr_entry.view_stride = raw.view_stride;
        wr_entry.has_sum     = raw.last;
        wr_entry.offset      = (st == tsvo_pkg::ST_OK) ? raw.offset : '0;
        wr_entry.total       = (st == tsvo_pkg::ST_OK) ? raw.total : '0;
        wr_entry.dims        = raw.dims;
        wr_entry.status      = st;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_comb
    begin
        head      = mem[rd_ptr_reg];
        out_valid = (count_reg != '0);
        show_dim  = head.has_dim && !phase_reg;
        advance   = out_valid && out_ready;
        pop       = advance && !(show_dim && head.has_sum);

        result.item_kind   = show_dim ? tsvo_pkg::RESULT_DIM : tsvo_pkg::RESULT_SUMMARY;
        result.view_size   = show_dim ? head.view_size : '0;
        result.view_stride = show_dim ? head.view_stride : '0;
        result.view_offset = show_dim ? '0 : head.offset;
        result.view_count  = show_dim ? '0 : head.total;
        result.view_dims   = show_dim ? '0 : head.dims;
        result.status      = show_dim ? tsvo_pkg::ST_OK : head.status;
        result.last_result = !show_dim;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            phase_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + tsvo_pkg::QUEUE_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + tsvo_pkg::QUEUE_PTR_W'(1);
                phase_reg  <= 1'b0;
            end
            else if (advance)
            begin
                phase_reg <= 1'b1;
            end
            count_reg <= count_reg + tsvo_pkg::QUEUE_CNT_W'(push)
                                   - tsvo_pkg::QUEUE_CNT_W'(pop);
        end
    end

    assign level = count_reg;

endmodule

// File: src/tensor_slice_view_offset.sv
// Pipeline: an accepted item is registered, decoded, multiplied, accumulated and then written
// to the result queue. Throughput: one transaction per cycle while the queue has room; a last
// dimension that keeps a dim yields two results, a dim and then a summary. The running offset
// and total update in one stage per transaction; the 8-entry result queue sets input ready.
// Reset: config registers clear, running state returns to the start of a view,
// result queue empties.
module tensor_slice_view_offset
#(
    parameter int DIM_LIMIT = 8
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [tsvo_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tsvo_pkg::CFG_W-1:0]     cfg_data,
    tsvo_in_if.sink                        in_ch,
    tsvo_out_if.source                     out_ch
);

    localparam logic [tsvo_pkg::DIMS_W-1:0] DIM_CAP =
        tsvo_pkg::DIMS_W'((DIM_LIMIT > tsvo_pkg::DIM_TOP) ? tsvo_pkg::DIM_TOP : DIM_LIMIT);

    logic                       view_mode_reg;
    logic [tsvo_pkg::OFF_W-1:0] base_offset_reg, base_count_reg;

    tsvo_pkg::item_t                  item;
    logic                             take;
    logic                             step_valid, ent_valid;
    tsvo_pkg::step_t                  step;
    tsvo_pkg::raw_t                   ent;
    tsvo_pkg::result_t                result;
    logic [tsvo_pkg::BUSY_W-1:0]      busy;
    logic [tsvo_pkg::QUEUE_CNT_W-1:0] level;
    logic [tsvo_pkg::FILL_W-1:0]      committed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_mode_reg   <= 1'b0;
            base_offset_reg <= '0;
            base_count_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tsvo_pkg::CFG_VIEW_MODE:   view_mode_reg   <= cfg_data[0];
                tsvo_pkg::CFG_BASE_OFFSET: base_offset_reg <= cfg_data[tsvo_pkg::OFF_W-1:0];
                tsvo_pkg::CFG_BASE_COUNT:  base_count_reg  <= cfg_data[tsvo_pkg::OFF_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // every transaction in flight holds a queue slot
    assign committed = tsvo_pkg::FILL_W'(level) + tsvo_pkg::FILL_W'(busy)
                     + tsvo_pkg::FILL_W'(ent_valid);
    assign in_ch.ready = (committed + tsvo_pkg::FILL_W'(1))
                         <= tsvo_pkg::FILL_W'(tsvo_pkg::QUEUE_DEPTH);
    assign take = in_ch.valid && in_ch.ready;

    always_comb
    begin
        item.dim_size     = in_ch.dim_size;
        item.dim_stride   = in_ch.dim_stride;
        item.slice_kind   = tsvo_pkg::kind_t'(in_ch.slice_kind);
        item.first_bound  = in_ch.first_bound;
        item.second_bound = in_ch.second_bound;
        item.last_dim     = in_ch.last_dim;
    end

    tsvo_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .item       (item),
        .view_mode  (view_mode_reg),
        .step_valid (step_valid),
        .step       (step),
        .busy       (busy)
    );

    tsvo_accum
    #(
        .DIM_LIMIT (DIM_LIMIT)
    )
    u_accum
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_valid  (step_valid),
        .step        (step),
        .base_offset (base_offset_reg),
        .ent_valid   (ent_valid),
        .ent         (ent)
    );

    tsvo_out_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (ent_valid),
        .raw        (ent),
        .base_count (base_count_reg),
        .out_ready  (out_ch.ready),
        .out_valid  (out_ch.valid),
        .result     (result),
        .level      (level)
    );

    assign out_ch.item_kind   = result.item_kind;
    assign out_ch.view_size   = result.view_size;
    assign out_ch.view_stride = result.view_stride;
    assign out_ch.view_offset = result.view_offset;
    assign out_ch.view_count  = result.view_count;
    assign out_ch.view_dims   = result.view_dims;
    assign out_ch.status      = result.status;
    assign out_ch.last_result = result.last_result;

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        committed <= tsvo_pkg::FILL_W'(tsvo_pkg::QUEUE_DEPTH))
        else $error("result queue overcommitted");

    a_last_reaches_queue: assert property (@(posedge clk) disable iff (!rst_n)
        take && in_ch.last_dim |-> ##5 (ent_valid && ent.last))
        else $error("last dimension did not produce a summary entry");

    a_failed_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.last_result && out_ch.status != tsvo_pkg::ST_OK
        |-> out_ch.view_offset == '0 && out_ch.view_count == '0)
        else $error("failed summary carries offset or total");

    a_dims_capped: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.last_result |-> out_ch.view_dims <= DIM_CAP)
        else $error("view dimension count beyond limit");

endmodule

// File: test/tb.sv
module tb;

    localparam int DIM_LIMIT     = 8;
    localparam int DIM_CAP       = DIM_LIMIT > tsvo_pkg::DIM_TOP ? tsvo_pkg::DIM_TOP
                                                                  : DIM_LIMIT;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int PRINT_CAP     = 60;

    localparam logic [tsvo_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [63:0] OFF_CAP  = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] SIZE_TOP = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] STEP_TOP = 64'h0000_00FF_FFFF_FFFF;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_write;
    logic [tsvo_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tsvo_pkg::CFG_W-1:0]     cfg_data;

    tsvo_in_if  in_ch();
    tsvo_out_if out_ch();

    tensor_slice_view_offset
    #(
        .DIM_LIMIT (DIM_LIMIT)
    )
    dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // register shadow and view accumulator
    logic              mode_reg;
    logic [63:0]       base_off_reg;
    logic [63:0]       base_tot_reg;
    logic [63:0]       acc_offset;
    logic [63:0]       acc_total;
    tsvo_pkg::status_t view_err;
    int                kept_dims;
    bit                fresh_view;
    bit                view_clip;

    tsvo_pkg::result_t awaited_results[$];
    int                mismatches;
    int                live_items;
    bit                tx_calm;
    bit                rx_calm;
    bit                rx_hold;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] sat_mul(logic [63:0] a, logic [63:0] b);
        if (a == 0 || b == 0)
            return 64'd0;
        if (a > OFF_CAP / b)
        begin
            view_clip = 1'b1;
            return OFF_CAP;
        end
        return a * b;
    endfunction

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        if (a + b > OFF_CAP)
        begin
            view_clip = 1'b1;
            return OFF_CAP;
        end
        return a + b;
    endfunction

    // works out the results of one accepted descriptor
    function automatic void advance_view(tsvo_pkg::item_t it);
        longint            b0;
        longint            b1;
        longint            span;
        logic [63:0]       stride;
        logic [63:0]       ksize;
        logic [63:0]       kstride;
        logic              keep;
        tsvo_pkg::status_t st;
        tsvo_pkg::result_t r;
        if (fresh_view)
        begin
            acc_offset = base_off_reg;
            acc_total  = 64'd1;
            view_err   = tsvo_pkg::ST_OK;
            kept_dims  = 0;
            view_clip  = 1'b0;
            fresh_view = 1'b0;
        end
        b0      = longint'({{32{it.first_bound[tsvo_pkg::BOUND_W-1]}}, it.first_bound});
        b1      = longint'({{32{it.second_bound[tsvo_pkg::BOUND_W-1]}}, it.second_bound});
        span    = longint'({33'b0, it.dim_size});
        stride  = {24'b0, it.dim_stride};
        keep    = 1'b0;
        ksize   = 64'd0;
        kstride = 64'd0;
        if (view_err == tsvo_pkg::ST_OK || it.last_dim)
            live_items++;
        if (view_err == tsvo_pkg::ST_OK)
        begin
            case (it.slice_kind)
                tsvo_pkg::KIND_ALL:
                begin
                    keep    = 1'b1;
                    ksize   = span;
                    kstride = stride;
                end
                tsvo_pkg::KIND_INDEX:
                begin
                    if (mode_reg && b0 < 0)
                        b0 += span;
                    if (b0 < 0 || b0 >= span)
                        view_err = tsvo_pkg::ST_INDEX;
                    else
                    begin
                        acc_offset = sat_add(acc_offset, sat_mul(b0, stride));
                        if (!mode_reg)
                        begin
                            keep  = 1'b1;
                            ksize = 64'd1;
                        end
                    end
                end
                tsvo_pkg::KIND_RANGE:
                begin
                    if (mode_reg)
                    begin
                        if (b0 < 0)
                            b0 += span;
                        if (b1 < 0)
                            b1 += span;
                    end
                    if (b0 < 0 || b1 < b0 || b1 >= span)
                        view_err = tsvo_pkg::ST_RANGE;
                    else
                    begin
                        acc_offset = sat_add(acc_offset, sat_mul(b0, stride));
                        keep    = 1'b1;
                        ksize   = b1 - b0 + 1;
                        kstride = stride;
                    end
                end
                default:
                    view_err = tsvo_pkg::ST_KIND;
            endcase
            if (keep)
            begin
                if (kept_dims >= DIM_CAP)
                    view_err = tsvo_pkg::ST_KIND;
                else
                begin
                    acc_total = sat_mul(acc_total, ksize);
                    kept_dims++;
                    r             = '0;
                    r.item_kind   = tsvo_pkg::RESULT_DIM;
                    r.view_size   = ksize[tsvo_pkg::SIZE_W-1:0];
                    r.view_stride = kstride[tsvo_pkg::STRIDE_W-1:0];
                    awaited_results.push_back(r);
                end
            end
        end
        if (it.last_dim)
        begin
            st = view_err;
            if (st == tsvo_pkg::ST_OK)
            begin
                if (acc_offset >= base_tot_reg)
                    st = tsvo_pkg::ST_OFFSET;
                else if (acc_offset + acc_total > base_tot_reg || view_clip)
                    st = tsvo_pkg::ST_REGION;
            end
            r             = '0;
            r.item_kind   = tsvo_pkg::RESULT_SUMMARY;
            r.last_result = 1'b1;
            r.view_dims   = kept_dims[tsvo_pkg::DIMS_W-1:0];
            r.status      = st;
            if (st == tsvo_pkg::ST_OK)
            begin
                r.view_offset = acc_offset[tsvo_pkg::OFF_W-1:0];
                r.view_count  = acc_total[tsvo_pkg::OFF_W-1:0];
            end
            awaited_results.push_back(r);
            fresh_view = 1'b1;
        end
    endfunction

    function automatic tsvo_pkg::item_t make_dim(logic [63:0] size, logic [63:0] stride,
                                                 tsvo_pkg::kind_t kind, int b0, int b1,
                                                 bit last);
        tsvo_pkg::item_t it;
        it.dim_size     = size[tsvo_pkg::SIZE_W-1:0];
        it.dim_stride   = stride[tsvo_pkg::STRIDE_W-1:0];
        it.slice_kind   = kind;
        it.first_bound  = b0;
        it.second_bound = b1;
        it.last_dim     = last;
        return it;
    endfunction

    // mostly well-formed descriptors with random content, some broken ones
    function automatic tsvo_pkg::item_t random_dim(bit last);
        int unsigned     size;
        logic [63:0]     stride;
        tsvo_pkg::kind_t kind;
        int              lo;
        int              hi;
        int              r;
        r = $urandom_range(0, 99);
        if (r < 3)
            size = 0;
        else if (r < 88)
            size = $urandom_range(1, 12);
        else if (r < 97)
            size = $urandom_range(13, 5000);
        else
            size = $urandom & 32'h7FFF_FFFF;
        r = $urandom_range(0, 99);
        if (r < 5)
            stride = 64'd0;
        else if (r < 85)
            stride = $urandom_range(1, 40);
        else if (r < 95)
            stride = $urandom_range(1, 1 << 20);
        else
            stride = rand64() & STEP_TOP;
        r = $urandom_range(0, 99);
        if (r < 40)
            kind = tsvo_pkg::KIND_ALL;
        else if (r < 70)
            kind = tsvo_pkg::KIND_INDEX;
        else if (r < 95)
            kind = tsvo_pkg::KIND_RANGE;
        else
            kind = tsvo_pkg::KIND_BAD;
        lo = int'($urandom);
        hi = int'($urandom);
        if (kind == tsvo_pkg::KIND_INDEX)
        begin
            if ($urandom_range(0, 99) < 85 && size != 0)
            begin
                lo = $urandom_range(0, size - 1);
                if (mode_reg && $urandom_range(0, 1))
                    lo = lo - int'(size);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: lo = int'(size);
                    1: lo = -1;
                    2: lo = -int'(size) - 1;
                    default: ;
                endcase
            end
        end
        else if (kind == tsvo_pkg::KIND_RANGE)
        begin
            if ($urandom_range(0, 99) < 80 && size != 0)
            begin
                lo = $urandom_range(0, size - 1);
                hi = $urandom_range(lo, size - 1);
                if (mode_reg && $urandom_range(0, 1))
                    lo = lo - int'(size);
                if (mode_reg && $urandom_range(0, 1))
                    hi = hi - int'(size);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        lo = 0;
                        hi = int'(size);
                    end
                    1:
                    begin
                        lo = 1;
                        hi = 0;
                    end
                    2:
                    begin
                        lo = -int'(size) - 1;
                        hi = 0;
                    end
                    default: ;
                endcase
            end
        end
        return make_dim(size, stride, kind, lo, hi, last);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_CAP)
            $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input tsvo_pkg::item_t it);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        repeat (gap) @(negedge clk);
        in_ch.dim_size     = it.dim_size;
        in_ch.dim_stride   = it.dim_stride;
        in_ch.slice_kind   = it.slice_kind;
        in_ch.first_bound  = it.first_bound;
        in_ch.second_bound = it.second_bound;
        in_ch.last_dim     = it.last_dim;
        in_ch.valid        = 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        advance_view(it);
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic write_reg(input logic [tsvo_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] data);
        cfg_index = idx;
        cfg_data  = data[tsvo_pkg::CFG_W-1:0];
        cfg_write = 1'b1;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            tsvo_pkg::CFG_VIEW_MODE:   mode_reg     = data[0];
            tsvo_pkg::CFG_BASE_OFFSET: base_off_reg = data & OFF_CAP;
            tsvo_pkg::CFG_BASE_COUNT:  base_tot_reg = data & OFF_CAP;
            default: ;
        endcase
    endtask

    // no results outstanding, then let any result-free transactions leave the pipe
    task automatic drain();
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_random_views(input int quota);
        int start;
        int n;
        int r;
        start = live_items;
        while (live_items - start < quota)
        begin
            r = $urandom_range(0, 99);
            if (r < 85)
                n = $urandom_range(1, 5);
            else if (r < 95)
                n = $urandom_range(6, 8);
            else
                n = $urandom_range(9, 11);
            for (int i = 0; i < n; i++)
                send_item(random_dim(i == n - 1));
        end
    endtask

    task automatic test_directed_cases();
        write_reg(tsvo_pkg::CFG_BASE_COUNT, 64'd1 << 20);
        write_reg(tsvo_pkg::CFG_VIEW_MODE, 64'd0);
        write_reg(tsvo_pkg::CFG_BASE_OFFSET, 64'd100);
        send_item(make_dim(SIZE_TOP, STEP_TOP, tsvo_pkg::KIND_ALL,
                           32'h7FFF_FFFF, 32'h8000_0000, 1));
        send_item(make_dim(1, 5, tsvo_pkg::KIND_INDEX, 0, 0, 1));
        send_item(make_dim(4, 5, tsvo_pkg::KIND_INDEX, -1, 0, 1));
        send_item(make_dim(10, 3, tsvo_pkg::KIND_RANGE, 2, 5, 0));
        send_item(make_dim(10, 3, tsvo_pkg::KIND_BAD, 0, 0, 1));
        // zero sized dim kept whole: total drops to zero
        send_item(make_dim(0, 9, tsvo_pkg::KIND_ALL, 0, 0, 1));
        send_item(make_dim(0, 9, tsvo_pkg::KIND_INDEX, 0, 0, 1));
        send_item(make_dim(10, 2, tsvo_pkg::KIND_RANGE, 3, 2, 1));
        send_item(make_dim(4, 2, tsvo_pkg::KIND_INDEX, 4, 0, 1));
        // error first, later dims ignored
        send_item(make_dim(3, 1, tsvo_pkg::KIND_BAD, 0, 0, 0));
        send_item(make_dim(3, 1, tsvo_pkg::KIND_ALL, 0, 0, 1));
        send_item(make_dim(SIZE_TOP, STEP_TOP, tsvo_pkg::KIND_INDEX, 32'h7FFF_FFFE, 0, 1));
        send_item(make_dim(SIZE_TOP, 1, tsvo_pkg::KIND_RANGE,
                           32'h8000_0000, 32'h7FFF_FFFF, 1));
        for (int i = 0; i <= DIM_LIMIT; i++)
            send_item(make_dim(1, 1, tsvo_pkg::KIND_ALL, 0, 0, i == DIM_LIMIT));
        drain();
        write_reg(tsvo_pkg::CFG_VIEW_MODE, 64'd1);
        send_item(make_dim(4, 7, tsvo_pkg::KIND_INDEX, -1, 0, 0));
        send_item(make_dim(5, 2, tsvo_pkg::KIND_RANGE, -3, -1, 1));
        send_item(make_dim(5, 2, tsvo_pkg::KIND_RANGE, -10, -1, 1));
    endtask

    task automatic test_mode_keep();
        drain();
        write_reg(tsvo_pkg::CFG_VIEW_MODE, 64'd0);
        write_reg(tsvo_pkg::CFG_BASE_OFFSET, $urandom_range(0, 4096));
        write_reg(tsvo_pkg::CFG_BASE_COUNT, $urandom_range(1 << 16, 1 << 24));
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        send_random_views(60);
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        send_random_views(180);
        drain();
        write_reg(tsvo_pkg::CFG_BASE_OFFSET, $urandom_range(0, 64));
        write_reg(tsvo_pkg::CFG_BASE_COUNT, $urandom_range(0, 2000));
        send_random_views(110);
    endtask

    task automatic test_mode_wrap();
        drain();
        write_reg(tsvo_pkg::CFG_VIEW_MODE, 64'd1);
        write_reg(tsvo_pkg::CFG_BASE_OFFSET, $urandom_range(0, 1000));
        write_reg(tsvo_pkg::CFG_BASE_COUNT, $urandom_range(1 << 18, 1 << 26));
        send_random_views(170);
        drain();
        write_reg(tsvo_pkg::CFG_BASE_OFFSET, rand64() & OFF_CAP);
        write_reg(tsvo_pkg::CFG_BASE_COUNT, rand64() & OFF_CAP);
        tx_calm = 1'b1;
        send_random_views(40);
        tx_calm = 1'b0;
        drain();
        write_reg(tsvo_pkg::CFG_BASE_OFFSET, 64'd0);
        write_reg(tsvo_pkg::CFG_BASE_COUNT, $urandom_range(1 << 18, 1 << 26));
        send_random_views(140);
    endtask

    task automatic test_register_extremes();
        drain();
        write_reg(tsvo_pkg::CFG_VIEW_MODE, 64'd0);
        write_reg(tsvo_pkg::CFG_BASE_OFFSET, 64'd0);
        write_reg(tsvo_pkg::CFG_BASE_COUNT, OFF_CAP);
        // saturated total with an offset in range
        send_item(make_dim(SIZE_TOP, 1, tsvo_pkg::KIND_ALL, 0, 0, 0));
        send_item(make_dim(SIZE_TOP, 1, tsvo_pkg::KIND_ALL, 0, 0, 1));
        send_random_views(40);
        drain();
        write_reg(tsvo_pkg::CFG_BASE_OFFSET, OFF_CAP);
        send_item(make_dim(2, 1, tsvo_pkg::KIND_ALL, 0, 0, 1));
        send_item(make_dim(4, 3, tsvo_pkg::KIND_INDEX, 1, 0, 1));
        drain();
        write_reg(tsvo_pkg::CFG_BASE_OFFSET, 64'd0);
        write_reg(tsvo_pkg::CFG_BASE_COUNT, 64'd0);
        send_random_views(20);
        drain();
        // unused register index must leave the others alone
        write_reg(CFG_SPARE, rand64());
        write_reg(tsvo_pkg::CFG_BASE_COUNT, 64'd1 << 30);
        send_random_views(20);
    endtask

    task automatic test_output_stall();
        drain();
        write_reg(tsvo_pkg::CFG_VIEW_MODE, 64'd0);
        write_reg(tsvo_pkg::CFG_BASE_OFFSET, $urandom_range(0, 100));
        write_reg(tsvo_pkg::CFG_BASE_COUNT, 64'd1 << 22);
        rx_hold = 1'b1;
        tx_calm = 1'b1;
        send_random_views(50);
        tx_calm = 1'b0;
    endtask

    initial
    begin : drive_ready
        int stall_left;
        out_ch.ready = 1'b0;
        stall_left   = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (rx_hold)
            begin
                out_ch.ready = 1'b0;
                for (int held = 1; held < HOLD_CYCLES; held++)
                    @(negedge clk);
                rx_hold = 1'b0;
            end
            else if (stall_left > 0 && !rx_calm)
            begin
                out_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready = 1'b1;
                stall_left   = rx_calm ? 0 : pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        tsvo_pkg::result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (awaited_results.size() == 0)
                report_mismatch("unexpected transaction, item_kind", out_ch.item_kind, 0);
            else
            begin
                want = awaited_results.pop_front();
                if (out_ch.item_kind !== want.item_kind)
                    report_mismatch("item_kind", out_ch.item_kind, want.item_kind);
                if (out_ch.view_size !== want.view_size)
                    report_mismatch("view_size", out_ch.view_size, want.view_size);
                if (out_ch.view_stride !== want.view_stride)
                    report_mismatch("view_stride", out_ch.view_stride, want.view_stride);
                if (out_ch.view_offset !== want.view_offset)
                    report_mismatch("view_offset", out_ch.view_offset, want.view_offset);
                if (out_ch.view_count !== want.view_count)
                    report_mismatch("view_count", out_ch.view_count, want.view_count);
                if (out_ch.view_dims !== want.view_dims)
                    report_mismatch("view_dims", out_ch.view_dims, want.view_dims);
                if (out_ch.status !== want.status)
                    report_mismatch("status", out_ch.status, want.status);
                if (out_ch.last_result !== want.last_result)
                    report_mismatch("last_result", out_ch.last_result, want.last_result);
            end
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_write          = 1'b0;
        cfg_index          = tsvo_pkg::CFG_VIEW_MODE;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.dim_size     = '0;
        in_ch.dim_stride   = '0;
        in_ch.slice_kind   = tsvo_pkg::KIND_ALL;
        in_ch.first_bound  = '0;
        in_ch.second_bound = '0;
        in_ch.last_dim     = 1'b0;
        tx_calm            = 1'b0;
        rx_calm            = 1'b0;
        rx_hold            = 1'b0;
        mismatches         = 0;
        live_items         = 0;
        mode_reg           = 1'b0;
        base_off_reg       = 64'd0;
        base_tot_reg       = 64'd0;
        acc_offset         = 64'd0;
        acc_total          = 64'd1;
        view_err           = tsvo_pkg::ST_OK;
        kept_dims          = 0;
        fresh_view         = 1'b1;
        view_clip          = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed_cases();
        test_mode_keep();
        test_mode_wrap();
        test_register_extremes();
        test_output_stall();
        drain();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #12_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
